// File: design/swpw_pkg.sv
// ----------------------------------------------------------------------------
// swpw_pkg: shared types and constants of the single-wire frame transmitter
// Frame geometry, timer width, command codes, register map and the
// configuration and result structures.
// ----------------------------------------------------------------------------
package swpw_pkg;

  localparam int TIMER_WIDTH = 16;
  localparam int DEV_BITS    = 8;
  localparam int ADDR_BITS   = 3;
  localparam int DATA_BITS   = 8;
  localparam int FRAME_BITS  = DEV_BITS + ADDR_BITS + DATA_BITS;
  localparam int CNT_WIDTH   = $clog2(FRAME_BITS + 1);

  // Register map, byte address 4 * index.
  localparam int PADDR_WIDTH = 5;
  localparam logic [2:0] REG_SHORT  = 3'd0;
  localparam logic [2:0] REG_LONG   = 3'd1;
  localparam logic [2:0] REG_START  = 3'd2;
  localparam logic [2:0] REG_END    = 3'd3;
  localparam logic [2:0] REG_DEVICE = 3'd4;

  localparam logic [TIMER_WIDTH-1:0] TMAX = {TIMER_WIDTH{1'b1}};

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_ENABLE = 2'd2,
    OP_OFF    = 2'd3
  } op_e;

  typedef struct packed {
    logic [15:0]         short_ticks;
    logic [15:0]         long_ticks;
    logic [15:0]         start_ticks;
    logic [15:0]         end_ticks;
    logic [DEV_BITS-1:0] device_address;
  } cfg_t;

  typedef struct packed {
    logic ctrl_level;
    logic en_level;
    logic busy_res;
    logic rejected;
  } result_t;

  // Segment length for the timer; values beyond the timer range saturate.
  function automatic logic [TIMER_WIDTH-1:0] dur(input logic [15:0] v);
    logic [31:0] w;
    w = 32'(v);
    if (w > 32'(TMAX)) begin
      return TMAX;
    end
    return w[TIMER_WIDTH-1:0];
  endfunction

endpackage

// File: design/single_wire_pulse_width_frame_tx.sv
// ----------------------------------------------------------------------------
// single_wire_pulse_width_frame_tx: single-wire pulse-width frame transmitter
// Each input transaction (tick, write frame, enable, off) updates the frame
// sequencer in one pass and yields one result transaction with the control
// line level, enable pin level, busy flag and a reject flag for a write
// issued during a frame. One transaction is taken every clock cycle while
// input ready is high, a rate set by the one-pass sequencer update. Results
// go to an output register backed by one skid entry, so a new transaction
// is still accepted while one result waits; input ready drops only when
// both entries are full. Configuration must be written through the APB-style
// port at byte address 4 * index while the block is idle; nothing enforces it.
// ----------------------------------------------------------------------------
module single_wire_pulse_width_frame_tx import swpw_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [1:0]             op_i,
  input  logic [ADDR_BITS-1:0]   reg_addr_i,
  input  logic [DATA_BITS-1:0]   write_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   ctrl_level_o,
  output logic                   en_level_o,
  output logic                   busy_res_o,
  output logic                   rejected_o,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [PADDR_WIDTH-1:0] paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  cfg_t    cfg;
  result_t res;
  result_t out_q, out_d, skid_q, skid_d;
  logic    out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  logic    acc, take;

  swpw_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  swpw_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (acc),
    .op_i         (op_i),
    .reg_addr_i   (reg_addr_i),
    .write_data_i (write_data_i),
    .cfg_i        (cfg),
    .res_o        (res)
  );

  assign in_ready_o = !skid_valid_q;
  assign acc        = in_valid_i & in_ready_o;
  assign take       = out_valid_q & out_ready_i;

  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (take) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = 1'b0;
      end
    end
    // An accepted transaction implies the skid entry was empty.
    if (acc) begin
      if (!out_valid_q || take) begin
        out_d       = res;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = res;
        skid_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o  = out_valid_q;
  assign ctrl_level_o = out_q.ctrl_level;
  assign en_level_o   = out_q.en_level;
  assign busy_res_o   = out_q.busy_res;
  assign rejected_o   = out_q.rejected;

`ifndef NO_ASSERTIONS
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry holds a result while the output is empty");

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> out_valid_q)
    else $error("accepted transaction produced no result");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && take) |=> (out_q == $past(skid_q)))
    else $error("skid entry not forwarded in order");
`endif

endmodule

// File: design/swpw_regs.sv
// ----------------------------------------------------------------------------
// swpw_regs: configuration registers
// APB-style register file holding the segment durations and the device
// address. Writes complete in the access cycle; pready is tied high.
// ----------------------------------------------------------------------------
module swpw_regs import swpw_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [PADDR_WIDTH-1:0] paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  output cfg_t                   cfg_o
);

  cfg_t        cfg_q, cfg_d;
  logic [2:0]  idx;
  logic        wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[PADDR_WIDTH-1:2];
  assign wr_en  = psel & penable & pwrite & pready;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_SHORT:  cfg_d.short_ticks    = pwdata[15:0];
        REG_LONG:   cfg_d.long_ticks     = pwdata[15:0];
        REG_START:  cfg_d.start_ticks    = pwdata[15:0];
        REG_END:    cfg_d.end_ticks      = pwdata[15:0];
        REG_DEVICE: cfg_d.device_address = pwdata[DEV_BITS-1:0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SHORT:  prdata = 32'(cfg_q.short_ticks);
      REG_LONG:   prdata = 32'(cfg_q.long_ticks);
      REG_START:  prdata = 32'(cfg_q.start_ticks);
      REG_END:    prdata = 32'(cfg_q.end_ticks);
      REG_DEVICE: prdata = 32'(cfg_q.device_address);
      default:    prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.short_ticks    <= 16'd4;
      cfg_q.long_ticks     <= 16'd16;
      cfg_q.start_ticks    <= 16'd16;
      cfg_q.end_ticks      <= 16'd512;
      cfg_q.device_address <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// File: design/swpw_engine.sv
// ----------------------------------------------------------------------------
// swpw_engine: frame sequencer
// Holds the segment phase, bit counter, shift register and segment timer,
// and updates them in one pass for each accepted transaction.
// ----------------------------------------------------------------------------
module swpw_engine import swpw_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [1:0]           op_i,
  input  logic [ADDR_BITS-1:0] reg_addr_i,
  input  logic [DATA_BITS-1:0] write_data_i,
  input  cfg_t                 cfg_i,
  output result_t              res_o
);

  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_START    = 3'd1;
  localparam logic [2:0] PH_BIT_LOW  = 3'd2;
  localparam logic [2:0] PH_BIT_HIGH = 3'd3;
  localparam logic [2:0] PH_END_LOW  = 3'd4;
  localparam logic [2:0] PH_END_HIGH = 3'd5;

  logic [2:0]             phase_q, phase_d;
  logic [CNT_WIDTH-1:0]   cnt_q, cnt_d, cnt_dec;
  logic [FRAME_BITS-1:0]  shift_q, shift_d;
  logic [TIMER_WIDTH-1:0] timer_q, timer_d;
  logic                   ctrl_q, ctrl_d;
  logic                   en_q, en_d;
  logic                   rej;

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    shift_d = shift_q;
    timer_d = timer_q;
    ctrl_d  = ctrl_q;
    en_d    = en_q;
    rej     = 1'b0;
    cnt_dec = (cnt_q != '0) ? cnt_q - 1'b1 : cnt_q;
    if (step_i) begin
      unique case (op_i)
        OP_TICK: begin
          if (phase_q != PH_IDLE) begin
            if (timer_q <= TIMER_WIDTH'(1)) begin
              unique case (phase_q)
                PH_START: begin
                  phase_d = PH_BIT_LOW;
                  ctrl_d  = 1'b0;
                  timer_d = dur(shift_q[FRAME_BITS-1] ? cfg_i.short_ticks
                                                      : cfg_i.long_ticks);
                end
                PH_BIT_LOW: begin
                  phase_d = PH_BIT_HIGH;
                  ctrl_d  = 1'b1;
                  timer_d = dur(shift_q[FRAME_BITS-1] ? cfg_i.long_ticks
                                                      : cfg_i.short_ticks);
                end
                PH_BIT_HIGH: begin
                  shift_d = {shift_q[FRAME_BITS-2:0], 1'b0};
                  cnt_d   = cnt_dec;
                  ctrl_d  = 1'b0;
                  if (cnt_dec != '0) begin
                    phase_d = PH_BIT_LOW;
                    timer_d = dur(shift_q[FRAME_BITS-2] ? cfg_i.short_ticks
                                                        : cfg_i.long_ticks);
                  end else begin
                    phase_d = PH_END_LOW;
                    timer_d = dur(cfg_i.short_ticks);
                  end
                end
                PH_END_LOW: begin
                  phase_d = PH_END_HIGH;
                  ctrl_d  = 1'b1;
                  timer_d = dur(cfg_i.end_ticks);
                end
                default: begin
                  phase_d = PH_IDLE;
                  timer_d = '0;
                end
              endcase
            end else begin
              timer_d = timer_q - 1'b1;
            end
          end
        end
        OP_WRITE: begin
          if (phase_q != PH_IDLE) begin
            rej = 1'b1;
          end else begin
            shift_d = {cfg_i.device_address, reg_addr_i, write_data_i};
            cnt_d   = CNT_WIDTH'(FRAME_BITS);
            phase_d = PH_START;
            ctrl_d  = 1'b1;
            timer_d = dur(cfg_i.start_ticks);
          end
        end
        OP_ENABLE: begin
          en_d = 1'b1;
        end
        OP_OFF: begin
          ctrl_d  = 1'b0;
          en_d    = 1'b0;
          phase_d = PH_IDLE;
          cnt_d   = '0;
          shift_d = '0;
          timer_d = '0;
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end
  end

  assign res_o.ctrl_level = ctrl_d;
  assign res_o.en_level   = en_d;
  assign res_o.busy_res   = (phase_d != PH_IDLE);
  assign res_o.rejected   = rej;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      shift_q <= '0;
      timer_q <= '0;
      ctrl_q  <= 1'b0;
      en_q    <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      shift_q <= shift_d;
      timer_q <= timer_d;
      ctrl_q  <= ctrl_d;
      en_q    <= en_d;
    end
  end

`ifndef NO_ASSERTIONS
  // The counter never exceeds the frame length.
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_WIDTH'(FRAME_BITS))
    else $error("bit counter beyond frame length");

  // The line is low during the low half of a bit and of the end marker, and high while starting.
  a_bit_low_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_BIT_LOW || phase_q == PH_END_LOW) |-> !ctrl_q)
    else $error("control line high during a low segment");

  a_start_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_START) |-> (ctrl_q && cnt_q == CNT_WIDTH'(FRAME_BITS)))
    else $error("start segment with wrong level or count");

  // A rejected write leaves the frame state untouched.
  a_reject_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rej |=> ($stable(shift_q) && $stable(cnt_q) && phase_q != PH_IDLE))
    else $error("rejected write disturbed the frame");
`endif

endmodule
